/* rtl/huffman_encode_bit_packer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman encoder bit packer
// Concurrent check macros. They are empty when the code is built for synthesis.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_ENCODE_BIT_PACKER_ASSERT_SVH
`define HUFFMAN_ENCODE_BIT_PACKER_ASSERT_SVH

`ifndef SYNTHESIS
// The condition holds in the same cycle as the trigger.
`define HEBP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed: condition broken in the same cycle");
// The condition holds in the cycle after the trigger.
`define HEBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed: condition broken one cycle later");
`else
`define HEBP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define HEBP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/hebp_pkg.sv */
// ----------------------------------------------------------------------------
// Huffman encoder bit packer package
// Constants, codes and types shared by the bit packer modules.
// ----------------------------------------------------------------------------
package hebp_pkg;

   localparam int TABLE_DEPTH     = 256;
   localparam int MAX_CODE_LENGTH = 16;
   localparam int BYTE_BITS       = 8;
   localparam int TABLE_ADDR_W    = $clog2(TABLE_DEPTH);
   localparam int SYMBOL_W        = 8;
   localparam int CODE_W          = 16;
   localparam int LEN_W           = 5;
   localparam int PEND_W          = 3;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2
   } hebp_mode_type;

   typedef enum logic {
      KIND_DATA  = 1'b0,
      KIND_ERROR = 1'b1
   } hebp_kind_type;

   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  len;
   } hebp_entry_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] out_byte;
      hebp_kind_type        kind;
      logic                 last;
   } hebp_result_type;

   // Results caused by one item: count is 0, 1 or 2, first goes out first.
   typedef struct packed {
      logic [1:0]      count;
      hebp_result_type first;
      hebp_result_type second;
   } hebp_batch_type;

endpackage

/* rtl/hebp_code_table.sv */
// ----------------------------------------------------------------------------
// Code table
// Symbol code memory with one write port, one registered read port and
// per-entry valid bits so that reset empties the table at once.
// ----------------------------------------------------------------------------
module hebp_code_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              wr_en,
   input  logic [hebp_pkg::TABLE_ADDR_W-1:0] wr_addr,
   input  hebp_pkg::hebp_entry_type          wr_entry,
   input  logic                              rd_en,
   input  logic [hebp_pkg::TABLE_ADDR_W-1:0] rd_addr,
   output hebp_pkg::hebp_entry_type          rd_entry
);
   import hebp_pkg::*;

   hebp_entry_type         mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] valid_ff;
   hebp_entry_type         rd_entry_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // An entry never written since reset reads as no code.
   assign rd_entry = rd_valid_ff ? rd_entry_ff : '0;

endmodule

/* rtl/hebp_packer.sv */
// ----------------------------------------------------------------------------
// Bit packer
// Holds the bit accumulator and works out the results of one item.
// ----------------------------------------------------------------------------
module hebp_packer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  hebp_pkg::hebp_mode_type     mode,
   input  logic                        hit,
   input  hebp_pkg::hebp_entry_type    entry,
   output hebp_pkg::hebp_batch_type    batch,
   output logic [hebp_pkg::PEND_W-1:0] pending_bits
);
   import hebp_pkg::*;

   logic [BYTE_BITS-1:0]   acc_ff;
   logic [BYTE_BITS-1:0]   acc_in;
   logic [PEND_W-1:0]      pend_ff;
   logic [PEND_W-1:0]      pend_in;
   logic [LEN_W-1:0]       len;
   logic [CODE_W:0]        mask;
   logic [CODE_W-1:0]      masked;
   logic [3*BYTE_BITS-1:0] combined;
   logic [LEN_W-1:0]       total;

   always_comb begin
      len      = hit ? entry.len : '0;
      mask     = ~({(CODE_W+1){1'b1}} << len);
      masked   = entry.code & mask[CODE_W-1:0];
      // Accumulator bits above the pending count are always zero.
      combined = {{(2*BYTE_BITS){1'b0}}, acc_ff}
               | ({{BYTE_BITS{1'b0}}, masked} << pend_ff);
      total    = {{(LEN_W-PEND_W){1'b0}}, pend_ff} + len;
      batch    = '0;
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      unique case (mode)
         MODE_ENCODE: begin
            if (len == '0) begin
               batch.count        = 2'd1;
               batch.first.kind   = KIND_ERROR;
               batch.first.last   = 1'b1;
            end else begin
               if (total >= LEN_W'(2 * BYTE_BITS)) begin
                  batch.count           = 2'd2;
                  batch.first.out_byte  = combined[BYTE_BITS-1:0];
                  batch.second.out_byte = combined[2*BYTE_BITS-1:BYTE_BITS];
                  batch.second.last     = 1'b1;
                  acc_in                = combined[3*BYTE_BITS-1:2*BYTE_BITS];
               end else if (total >= LEN_W'(BYTE_BITS)) begin
                  batch.count          = 2'd1;
                  batch.first.out_byte = combined[BYTE_BITS-1:0];
                  batch.first.last     = 1'b1;
                  acc_in               = combined[2*BYTE_BITS-1:BYTE_BITS];
               end else begin
                  acc_in = combined[BYTE_BITS-1:0];
               end
               pend_in = total[PEND_W-1:0];
            end
         end
         MODE_FLUSH: begin
            if (pend_ff != '0) begin
               batch.count          = 2'd1;
               batch.first.out_byte = acc_ff;
               batch.first.last     = 1'b1;
            end
            acc_in  = '0;
            pend_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= '0;
      end else if (advance) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
      end
   end

   assign pending_bits = pend_ff;

endmodule

/* rtl/hebp_out_buffer.sv */
// ----------------------------------------------------------------------------
// Result buffer
// Two-entry result register that hands results out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module hebp_out_buffer (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  hebp_pkg::hebp_batch_type  batch,
   input  logic                      out_ready,
   output logic                      can_take,
   output logic                      out_valid,
   output hebp_pkg::hebp_result_type out_result,
   output logic [1:0]                count
);
   import hebp_pkg::*;

   hebp_result_type slot0_ff;
   hebp_result_type slot0_in;
   hebp_result_type slot1_ff;
   hebp_result_type slot1_in;
   logic [1:0]      count_ff;
   logic [1:0]      count_in;
   logic            pop;

   assign pop      = (count_ff != 2'd0) && out_ready;
   assign can_take = (count_ff == 2'd0) || ((count_ff == 2'd1) && pop);

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (load) begin
         slot0_in = batch.first;
         slot1_in = batch.second;
         count_in = batch.count;
      end else if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_valid  = (count_ff != 2'd0);
   assign out_result = slot0_ff;
   assign count      = count_ff;

endmodule

/* rtl/huffman_encode_bit_packer.sv */
// ----------------------------------------------------------------------------
// Huffman encoder bit packer
// Code table plus least-significant-bit-first packer of encoded symbols.
// ----------------------------------------------------------------------------
// Each item loads a table entry, encodes a byte symbol or flushes the partial
// byte; the mode travels in req_tuser. Items enter a first stage whose
// register sits alongside the registered table read, the packer works out
// the results of that stage combinationally, and up to two results land in a
// two-entry result buffer that drives the rsp_ side. An item is held in
// the first stage register until the result buffer can take its results. The
// block takes one item per cycle while each item causes at most one result
// and rsp_tready stays high; an encode that completes two bytes holds the
// stage until the buffer has room for both, because the result port gives out
// at most one byte per cycle from the result buffer. The table is emptied at
// reset through one valid flip-flop per entry, so no clearing pass is needed
// and items are taken from the first cycle after reset.
`include "huffman_encode_bit_packer_assert.svh"

module huffman_encode_bit_packer (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // symbol [7:0], code_bits [23:8],
                                   // code_length [28:24], zero [31:29]
   input  logic [1:0]  req_tuser,  // mode [1:0]
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte [7:0]
   output logic [0:0]  rsp_tuser,  // kind [0]
   output logic        rsp_tlast
);
   import hebp_pkg::*;

   hebp_mode_type   req_mode;
   logic [SYMBOL_W-1:0] req_symbol;
   logic [LEN_W-1:0]    req_len;
   logic            req_fire;
   logic            req_sym_ok;
   hebp_entry_type  wr_entry;
   logic            wr_en;
   hebp_entry_type  rd_entry;

   logic            s1_valid_ff;
   logic            s1_valid_in;
   hebp_mode_type   s1_mode_ff;
   logic            s1_hit_ff;
   logic            s1_advance;

   hebp_batch_type  batch;
   logic [PEND_W-1:0] pending_bits;
   logic            buf_can_take;
   hebp_result_type out_result;
   logic [1:0]      buf_count;

   // Input fields.
   assign req_mode   = hebp_mode_type'(req_tuser);
   assign req_symbol = req_tdata[7:0];
   assign req_len    = req_tdata[28:24];
   assign req_fire   = req_tvalid && req_tready;
   assign req_sym_ok = {1'b0, req_symbol} < (SYMBOL_W+1)'(TABLE_DEPTH);

   // A load writes the table as it is taken, so that an encode right behind
   // it already reads the new entry. Over-long lengths are clipped here.
   assign wr_en          = req_fire && (req_mode == MODE_LOAD) && req_sym_ok;
   assign wr_entry.code  = req_tdata[23:8];
   assign wr_entry.len   = (req_len > LEN_W'(MAX_CODE_LENGTH))
                         ? LEN_W'(MAX_CODE_LENGTH) : req_len;

   hebp_code_table u_table (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (req_symbol[TABLE_ADDR_W-1:0]),
      .wr_entry (wr_entry),
      .rd_en    (req_fire),
      .rd_addr  (req_symbol[TABLE_ADDR_W-1:0]),
      .rd_entry (rd_entry)
   );

   // First stage: it moves on when the result buffer can take its results.
   assign s1_advance  = s1_valid_ff && buf_can_take;
   assign req_tready  = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_mode_ff <= req_mode;
         s1_hit_ff  <= req_sym_ok;
      end
   end

   hebp_packer u_packer (
      .clock        (clock),
      .reset        (reset),
      .advance      (s1_advance),
      .mode         (s1_mode_ff),
      .hit          (s1_hit_ff),
      .entry        (rd_entry),
      .batch        (batch),
      .pending_bits (pending_bits)
   );

   hebp_out_buffer u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_advance),
      .batch      (batch),
      .out_ready  (rsp_tready),
      .can_take   (buf_can_take),
      .out_valid  (rsp_tvalid),
      .out_result (out_result),
      .count      (buf_count)
   );

   assign rsp_tdata = out_result.out_byte;
   assign rsp_tuser = out_result.kind;
   assign rsp_tlast = out_result.last;

   // The result buffer never holds more than two results.
   `HEBP_ASSERT_NOW(a_buf_count, clock, reset, 1'b1, buf_count <= 2'd2)
   // An error result is a lone, last result with a zero byte.
   `HEBP_ASSERT_NOW(a_err_shape, clock, reset, rsp_tvalid && (rsp_tuser == KIND_ERROR),
                    rsp_tlast && (rsp_tdata == 8'd0))
   // A flush leaving the first stage clears the pending bit count.
   `HEBP_ASSERT_NEXT(a_flush_clr, clock, reset, s1_advance && (s1_mode_ff == MODE_FLUSH),
                     pending_bits == '0)

endmodule
